// ----- design/smd_pkg.sv -----
// Shared types, codes and constants for the SAM MD tag builder.
// Depends on nothing; imported by every module of the block.
package smd_pkg;

    // Width of the match run as seen by a user; only the saturation limit follows from it
    localparam int unsigned RUN_BITS   = 16;
    localparam int unsigned DIGIT_CAP  = 99999;
    localparam int unsigned DIGITS     = 5;
    localparam int unsigned MAX_RES    = 7;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned DIG_IDX_W  = 3;

    localparam longint unsigned RUN_MAX   = (64'd1 << RUN_BITS) - 64'd1;
    localparam longint unsigned RUN_LIMIT = (RUN_MAX < DIGIT_CAP) ? RUN_MAX : DIGIT_CAP;

    // Saturation limit in decimal digits, least significant first
    localparam logic [3:0] LIM_D0 = 4'(RUN_LIMIT % 10);
    localparam logic [3:0] LIM_D1 = 4'((RUN_LIMIT / 10) % 10);
    localparam logic [3:0] LIM_D2 = 4'((RUN_LIMIT / 100) % 10);
    localparam logic [3:0] LIM_D3 = 4'((RUN_LIMIT / 1000) % 10);
    localparam logic [3:0] LIM_D4 = 4'((RUN_LIMIT / 10000) % 10);

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    localparam bcd_t RUN_LIMIT_BCD = {LIM_D4, LIM_D3, LIM_D2, LIM_D1, LIM_D0};

    // Characters
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [2:0] {
        OP_ALIGN     = 3'd0,
        OP_DEL_FIRST = 3'd1,
        OP_DEL_MORE  = 3'd2,
        OP_NOP       = 3'd3,
        OP_END       = 3'd4,
        OP_ABORT     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_END_FULL  = 2'd1,
        KIND_END_EMPTY = 2'd2,
        KIND_ABORT     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
    } entry_t;

    // All results caused by one request, in emission order from entry 0
    typedef struct packed {
        entry_t [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]     count;
    } burst_t;

    // Map a reference character onto A, C, G, T or N
    function automatic logic [7:0] base_letter(input logic [7:0] b);
        logic [7:0] res;
        res = CH_N;
        if (b == CH_A || b == CH_C || b == CH_G || b == CH_T)
            res = b;
        return res;
    endfunction

endpackage

// ----- design/sam_md_tag_builder.sv -----
// Top level of the SAM MD tag builder: request register and builder, then serialiser.
// Depends on smd_pkg, smd_core and smd_serial.
//
//  channel | direction | tdata                         | tuser       | tlast
//  s_*     | in        | query_base[7:0] ref_base[15:8] | op[2:0]     | -
//  m_*     | out       | out_char[7:0]                  | kind[1:0]   | final result
//
// Requests and bursts are registered; results leave one per cycle unless stalled.
// Requests with at most one result flow every cycle while m_tready is high.
// A request of n results, n at most seven, stalls the next until its last is taken.
// Reset clears the match run and the record flag; no clearing pass is needed.
// Back-pressure on m_tready stalls the serialiser and, through it, s_tready.
module sam_md_tag_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // query_base[7:0], ref_base[15:8]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import smd_pkg::*;

    logic   advance;
    logic   burst_valid;
    burst_t burst;

    // Register the request and build its results
    smd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_query    (s_tdata[7:0]),
        .in_ref      (s_tdata[15:8]),
        .advance     (advance),
        .burst_valid (burst_valid),
        .burst       (burst)
    );

    // Emit the results one per cycle while m_tready is high
    smd_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .out_kind    (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

// ----- design/smd_core.sv -----
// Input register, match run state and result burst builder.
// Depends on smd_pkg.
module smd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           in_op,
    input  logic [7:0]           in_query,
    input  logic [7:0]           in_ref,
    input  logic                 advance,
    output logic                 burst_valid,
    output smd_pkg::burst_t      burst
);
    import smd_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [7:0]  query_reg;
    logic [7:0]  ref_reg;
    bcd_t        run_reg;
    bcd_t        run_next;
    logic        emitted_reg;
    logic        emitted_next;

    bcd_t                 run_inc;
    logic                 inc_carry;
    logic [DIG_IDX_W-1:0] n_dig;
    logic [DIG_IDX_W-1:0] n_flush;
    logic                 flush;
    logic [1:0]           n_tail;
    entry_t               tail0;
    entry_t               tail1;
    logic [7:0]           letter;
    logic                 any_char;
    logic [CNT_W-1:0]     pos;

    assign in_ready    = !in_valid_reg || advance;
    assign burst_valid = in_valid_reg;
    assign letter      = base_letter(ref_reg);

    // Hold the request until the serialiser takes its burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg    <= in_op;
            query_reg <= in_query;
            ref_reg   <= in_ref;
        end
    end

    // Decimal increment of the run, saturating at the limit
    always_comb
    begin
        inc_carry = 1'b1;
        run_inc   = run_reg;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (inc_carry)
            begin
                if (run_reg[k] == 4'd9)
                begin
                    run_inc[k] = 4'd0;
                end
                else
                begin
                    run_inc[k] = run_reg[k] + 4'd1;
                    inc_carry  = 1'b0;
                end
            end
        end
        if (run_reg == RUN_LIMIT_BCD)
            run_inc = run_reg;
    end

    // Count significant digits of the pending run
    always_comb
    begin
        n_dig = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (run_reg[k] != 4'd0)
                n_dig = DIG_IDX_W'(k + 1);
        end
    end

    // Decode the operation into a flush, up to two tail results and the next state
    always_comb
    begin
        flush        = 1'b0;
        n_tail       = 2'd0;
        tail0        = '{ch: CH_NONE, kind: KIND_CHAR};
        tail1        = '{ch: CH_NONE, kind: KIND_CHAR};
        run_next     = run_reg;
        emitted_next = emitted_reg;
        case (op_t'(op_reg))
            OP_ALIGN:
            begin
                if (query_reg == ref_reg)
                begin
                    run_next = run_inc;
                end
                else
                begin
                    flush    = 1'b1;
                    n_tail   = 2'd1;
                    tail0.ch = letter;
                    run_next = '0;
                end
            end
            OP_DEL_FIRST:
            begin
                flush    = 1'b1;
                n_tail   = 2'd2;
                tail0.ch = CH_CARET;
                tail1.ch = letter;
                run_next = '0;
            end
            OP_DEL_MORE:
            begin
                n_tail   = 2'd1;
                tail0.ch = letter;
            end
            OP_END:
            begin
                flush      = 1'b1;
                n_tail     = 2'd1;
                tail0.kind = (emitted_reg || n_dig != '0) ? KIND_END_FULL : KIND_END_EMPTY;
                run_next   = '0;
            end
            OP_ABORT:
            begin
                n_tail     = 2'd1;
                tail0.kind = KIND_ABORT;
                run_next   = '0;
            end
            default:
            begin
                n_tail = 2'd0;
            end
        endcase
        n_flush  = flush ? n_dig : '0;
        any_char = (n_flush != '0) || (tail0.kind == KIND_CHAR && n_tail != 2'd0);
        if (any_char)
            emitted_next = 1'b1;
        if (op_t'(op_reg) == OP_END || op_t'(op_reg) == OP_ABORT)
            emitted_next = 1'b0;
    end

    // Place digits most significant first, then the tail results
    always_comb
    begin
        burst.count = CNT_W'(n_flush) + CNT_W'(n_tail);
        for (int i = 0; i < MAX_RES; i++)
        begin
            pos          = CNT_W'(i);
            burst.ent[i] = '{ch: CH_NONE, kind: KIND_CHAR};
            if (pos < CNT_W'(n_flush))
            begin
                for (int k = 0; k < DIGITS; k++)
                begin
                    if (CNT_W'(i + k + 1) == CNT_W'(n_flush))
                        burst.ent[i].ch = CH_ZERO + {4'd0, run_reg[k]};
                end
            end
            else if (pos == CNT_W'(n_flush))
            begin
                burst.ent[i] = tail0;
            end
            else
            begin
                burst.ent[i] = tail1;
            end
        end
    end

    // Advance the record state when the burst moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            emitted_reg <= 1'b0;
        end
        else if (advance)
        begin
            run_reg     <= run_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ----- design/smd_serial.sv -----
// Burst register and result serialiser: one result per cycle while out_ready is high.
// Depends on smd_pkg.
module smd_serial (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            burst_valid,
    input  smd_pkg::burst_t burst,
    output logic            advance,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_char,
    output logic [1:0]      out_kind,
    output logic            out_last
);
    import smd_pkg::*;

    burst_t           burst_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             take;
    logic             can_load;

    assign out_valid = busy_reg;
    assign out_char  = burst_reg.ent[idx_reg].ch;
    assign out_kind  = burst_reg.ent[idx_reg].kind;
    assign out_last  = (idx_reg == burst_reg.count - CNT_W'(1));
    assign take      = busy_reg && out_ready;
    assign can_load  = !busy_reg || (take && out_last);
    assign advance   = burst_valid && can_load;

    // Step through the burst, reload when idle or on its last result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (advance)
        begin
            busy_reg <= (burst.count != '0);
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (out_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            burst_reg <= burst;
    end

endmodule

// ----- design/smd_checker.sv -----
// Port-level checks for the SAM MD tag builder, bound to the top level.
// Depends on smd_pkg and sam_md_tag_builder.
module smd_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import smd_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // End and abort results close their request and carry no character
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_CHAR |-> m_tlast && m_tdata == CH_NONE)
        else $error("end or abort result malformed");

    // A character closing a request is a base letter, never a digit or caret
    a_char_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser == KIND_CHAR |->
            (m_tdata == CH_A || m_tdata == CH_C || m_tdata == CH_G
             || m_tdata == CH_T || m_tdata == CH_N))
        else $error("final character is not a base letter");

    // A caret never closes its request, so another result of the same request follows it
    a_caret: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CHAR && m_tdata == CH_CARET |-> !m_tlast)
        else $error("caret closes a request");

    // Drop output valid during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind sam_md_tag_builder smd_port_checks u_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
